>>> hw/rtl/lud_pkg.sv
// Shared constants, command and status types for the LU decomposition core.
// Used by the controller, the datapath and the top level; depends on nothing.
package lud_pkg;

  localparam int MAX_SIZE   = 8;
  localparam int IDX_W      = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int DEPTH      = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int DIV_W      = DATA_W + FRAC_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int SIZE_W     = 4;
  localparam int POS_W      = 3;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

  // Destination of a store read, applied in the cycle after the read is issued.
  localparam int DST_W = 3;
  localparam logic [DST_W-1:0] DST_NONE = 3'd0;
  localparam logic [DST_W-1:0] DST_SRCH = 3'd1;
  localparam logic [DST_W-1:0] DST_PIV  = 3'd2;
  localparam logic [DST_W-1:0] DST_NUM  = 3'd3;
  localparam logic [DST_W-1:0] DST_UJK  = 3'd4;
  localparam logic [DST_W-1:0] DST_UIK  = 3'd5;
  localparam logic [DST_W-1:0] DST_OUT  = 3'd6;

  typedef struct packed {
    logic              load_wr;
    logic              init;
    logic              srch_clr;
    logic              skip_set;
    logic              swap_a;
    logic              swap_b;
    logic              rd_en;
    logic [DST_W-1:0]  dst;
    logic              rd_last;
    logic              mul;
    logic              adj;
    logic              u_wr;
    logic              l_wr;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  pj;
  } cmd_t;

  typedef struct packed {
    logic best_zero;
    logic div_done;
  } status_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [IDX_W-1:0] p,
                                                   input logic [IDX_W-1:0] c);
    return ADDR_W'(ADDR_W'(p) * ADDR_W'(MAX_SIZE) + ADDR_W'(c));
  endfunction

endpackage

>>> hw/rtl/lud_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used by the datapath for the upper and lower factor stores.
module lud_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/lud_datapath.sv
// Datapath: factor stores, row map, pivot search, serial divider, multiply,
// saturation and output word registers. Depends on lud_pkg and lud_ram.
module lud_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  lud_pkg::cmd_t                      cmd,
  input  logic signed [lud_pkg::DATA_W-1:0]  entry_value,
  output lud_pkg::status_t                   status,
  output logic [lud_pkg::IDX_W-1:0]          out_row,
  output logic [lud_pkg::IDX_W-1:0]          out_col,
  output logic signed [lud_pkg::DATA_W-1:0]  out_lower,
  output logic signed [lud_pkg::DATA_W-1:0]  out_upper,
  output logic [lud_pkg::IDX_W-1:0]          out_src,
  output logic                               out_sing,
  output logic                               out_last
);

  logic [lud_pkg::IDX_W-1:0]  row_map [lud_pkg::MAX_SIZE];
  logic [lud_pkg::IDX_W-1:0]  map_idx;
  logic [lud_pkg::IDX_W-1:0]  map_sel;
  logic [lud_pkg::IDX_W-1:0]  swap_tmp;
  logic [lud_pkg::MAX_SIZE-1:0] skip;
  logic                       singular;

  logic [lud_pkg::ADDR_W-1:0] u_waddr;
  logic [lud_pkg::ADDR_W-1:0] map_addr;
  logic [lud_pkg::DATA_W-1:0] u_wdata;
  logic [lud_pkg::DATA_W-1:0] u_rdata;
  logic [lud_pkg::DATA_W-1:0] l_rdata;
  logic                       u_we;

  logic [lud_pkg::DST_W-1:0]  dst_q;
  logic [lud_pkg::IDX_W-1:0]  row_q;
  logic [lud_pkg::IDX_W-1:0]  col_q;
  logic [lud_pkg::IDX_W-1:0]  src_q;
  logic                       last_q;

  logic [lud_pkg::DATA_W-1:0] best;
  logic [lud_pkg::IDX_W-1:0]  prow;
  logic [lud_pkg::DATA_W-1:0] mag;
  logic signed [lud_pkg::DATA_W-1:0] piv;
  logic signed [lud_pkg::DATA_W-1:0] ujk;
  logic signed [lud_pkg::DATA_W-1:0] uik;
  logic signed [lud_pkg::DATA_W-1:0] lval;

  logic                          div_busy;
  logic                          div_done;
  logic [lud_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [lud_pkg::DIV_W-1:0]     div_num;
  logic [lud_pkg::DIV_W-1:0]     div_q;
  logic [lud_pkg::DATA_W-1:0]    div_rem;
  logic [lud_pkg::DATA_W-1:0]    div_d;
  logic                          div_neg;
  logic [lud_pkg::DATA_W:0]      trial;
  logic                          ge;
  logic [lud_pkg::DATA_W-1:0]    rem_n;
  logic [lud_pkg::DIV_W-1:0]     q_n;
  logic signed [lud_pkg::DATA_W-1:0] l_sat;

  logic signed [63:0]             prod;
  logic signed [63:0]             padj;
  logic signed [63:0]             psh;
  logic signed [lud_pkg::DATA_W-1:0] ps;
  logic signed [lud_pkg::DATA_W:0]   diff;
  logic signed [lud_pkg::DATA_W-1:0] diff_sat;

  assign map_idx  = cmd.swap_b ? prow : cmd.row;
  assign map_sel  = row_map[map_idx];
  assign map_addr = lud_pkg::store_addr(map_sel, cmd.col);
  assign u_we     = cmd.load_wr | cmd.u_wr;
  assign u_waddr  = cmd.load_wr ? lud_pkg::store_addr(cmd.row, cmd.col) : map_addr;
  assign u_wdata  = cmd.load_wr ? entry_value : diff_sat;

  lud_ram #(.WIDTH(lud_pkg::DATA_W), .DEPTH(lud_pkg::DEPTH)) u_upper (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_waddr),
    .wdata (u_wdata),
    .re    (cmd.rd_en),
    .raddr (map_addr),
    .rdata (u_rdata)
  );

  lud_ram #(.WIDTH(lud_pkg::DATA_W), .DEPTH(lud_pkg::DEPTH)) u_lower (
    .clk   (clk),
    .we    (cmd.l_wr),
    .waddr (map_addr),
    .wdata (lval),
    .re    (cmd.rd_en),
    .raddr (map_addr),
    .rdata (l_rdata)
  );

  assign mag = u_rdata[lud_pkg::DATA_W-1] ? lud_pkg::DATA_W'(-u_rdata) : u_rdata;

  // One restoring division step per cycle on magnitudes.
  always_comb begin
    trial = {div_rem, div_num[lud_pkg::DIV_W-1]};
    ge    = trial >= {1'b0, div_d};
    rem_n = ge ? lud_pkg::DATA_W'(trial - {1'b0, div_d}) : trial[lud_pkg::DATA_W-1:0];
    q_n   = {div_q[lud_pkg::DIV_W-2:0], ge};
    if (!div_neg) begin
      l_sat = (q_n > lud_pkg::DIV_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF
                                                   : signed'(q_n[lud_pkg::DATA_W-1:0]);
    end else begin
      l_sat = (q_n > lud_pkg::DIV_W'(32'h8000_0000)) ? 32'sh8000_0000
                                                   : signed'(-q_n[lud_pkg::DATA_W-1:0]);
    end
  end

  // Product scaled back by the fraction width, rounding toward zero; saturating uik - ps.
  always_comb begin
    padj = prod + (prod[63] ? 64'sd65535 : 64'sd0);
    psh  = padj >>> lud_pkg::FRAC_W;
    diff = {uik[lud_pkg::DATA_W-1], uik} - {ps[lud_pkg::DATA_W-1], ps};
    if (diff[lud_pkg::DATA_W] != diff[lud_pkg::DATA_W-1]) begin
      diff_sat = diff[lud_pkg::DATA_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      diff_sat = diff[lud_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      for (int m = 0; m < lud_pkg::MAX_SIZE; m++) begin
        row_map[m] <= lud_pkg::IDX_W'(m);
      end
      skip     <= '0;
      singular <= 1'b0;
    end else begin
      if (cmd.swap_b) begin
        row_map[cmd.pj] <= map_sel;
        if (prow != cmd.pj) begin
          row_map[prow] <= swap_tmp;
        end
      end
      if (cmd.skip_set) begin
        skip[cmd.pj] <= 1'b1;
        singular     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_q    <= lud_pkg::DST_NONE;
      div_busy <= 1'b0;
      div_done <= 1'b0;
    end else begin
      dst_q    <= cmd.rd_en ? cmd.dst : lud_pkg::DST_NONE;
      div_done <= 1'b0;
      if (dst_q == lud_pkg::DST_NUM) begin
        div_busy <= 1'b1;
      end else if (div_busy && div_cnt == '0) begin
        div_busy <= 1'b0;
        div_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_q  <= cmd.row;
    col_q  <= cmd.col;
    src_q  <= map_sel;
    last_q <= cmd.rd_last;
    if (cmd.swap_a) begin
      swap_tmp <= map_sel;
    end
    if (cmd.srch_clr) begin
      best <= '0;
      prow <= cmd.pj;
    end
    if (cmd.mul) begin
      prod <= ujk * lval;
    end
    if (cmd.adj) begin
      if (psh > 64'sd2147483647) begin
        ps <= 32'sh7FFF_FFFF;
      end else if (psh < -64'sd2147483648) begin
        ps <= 32'sh8000_0000;
      end else begin
        ps <= psh[lud_pkg::DATA_W-1:0];
      end
    end
    if (div_busy) begin
      div_rem <= rem_n;
      div_q   <= q_n;
      div_num <= {div_num[lud_pkg::DIV_W-2:0], 1'b0};
      div_cnt <= div_cnt - 1'b1;
      if (div_cnt == '0) begin
        lval <= l_sat;
      end
    end
    case (dst_q)
      lud_pkg::DST_SRCH: begin
        if (mag > best) begin
          best <= mag;
          prow <= row_q;
        end
      end
      lud_pkg::DST_PIV: piv <= u_rdata;
      lud_pkg::DST_NUM: begin
        div_num <= {mag, lud_pkg::FRAC_W'(0)};
        div_d   <= piv[lud_pkg::DATA_W-1] ? lud_pkg::DATA_W'(-piv) : piv;
        div_neg <= u_rdata[lud_pkg::DATA_W-1] ^ piv[lud_pkg::DATA_W-1];
        div_rem <= '0;
        div_q   <= '0;
        div_cnt <= lud_pkg::DIV_CNT_W'(lud_pkg::DIV_W - 1);
      end
      lud_pkg::DST_UJK: ujk <= u_rdata;
      lud_pkg::DST_UIK: uik <= u_rdata;
      lud_pkg::DST_OUT: begin
        out_row  <= row_q;
        out_col  <= col_q;
        out_src  <= src_q;
        out_sing <= singular;
        out_last <= last_q;
        if (col_q < row_q) begin
          out_lower <= skip[col_q] ? '0 : l_rdata;
        end else if (col_q == row_q) begin
          out_lower <= lud_pkg::Q_ONE;
        end else begin
          out_lower <= '0;
        end
        out_upper <= (col_q >= row_q) ? u_rdata : '0;
      end
      default: ;
    endcase
  end

  assign status.best_zero = (best == '0);
  assign status.div_done  = div_done;

endmodule

>>> hw/rtl/lud_controller.sv
// Controller state machine: load counting, column/row/element sequencing and
// result streaming. Depends on lud_pkg; drives the datapath through cmd_t.
module lud_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [lud_pkg::SIZE_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  lud_pkg::status_t              status,
  output lud_pkg::cmd_t                 cmd
);

  localparam logic [4:0] ST_LOAD  = 5'd0;
  localparam logic [4:0] ST_INIT  = 5'd1;
  localparam logic [4:0] ST_COL   = 5'd2;
  localparam logic [4:0] ST_SRD   = 5'd3;
  localparam logic [4:0] ST_SEND  = 5'd4;
  localparam logic [4:0] ST_SDEC  = 5'd5;
  localparam logic [4:0] ST_SWAPA = 5'd6;
  localparam logic [4:0] ST_SWAPB = 5'd7;
  localparam logic [4:0] ST_PRD   = 5'd8;
  localparam logic [4:0] ST_DRD   = 5'd9;
  localparam logic [4:0] ST_DWAIT = 5'd10;
  localparam logic [4:0] ST_LWR   = 5'd11;
  localparam logic [4:0] ST_ERJ   = 5'd12;
  localparam logic [4:0] ST_ERI   = 5'd13;
  localparam logic [4:0] ST_EMUL  = 5'd14;
  localparam logic [4:0] ST_EADJ  = 5'd15;
  localparam logic [4:0] ST_EWR   = 5'd16;
  localparam logic [4:0] ST_OREAD = 5'd17;
  localparam logic [4:0] ST_OSHOW = 5'd18;
  localparam logic [4:0] ST_OLAT  = 5'd19;

  logic [4:0]                  state, state_next;
  logic [lud_pkg::SIZE_W-1:0]  size;
  logic [lud_pkg::IDX_W-1:0]   nm1;
  logic [lud_pkg::IDX_W-1:0]   lr, lr_next, lc, lc_next;
  logic [lud_pkg::IDX_W-1:0]   j, j_next, i, i_next, k, k_next;

  // A size of zero behaves as one and sizes beyond the maximum are clamped.
  always_comb begin
    if (size == '0) begin
      nm1 = '0;
    end else if (size > lud_pkg::SIZE_W'(lud_pkg::MAX_SIZE)) begin
      nm1 = lud_pkg::IDX_W'(lud_pkg::MAX_SIZE - 1);
    end else begin
      nm1 = lud_pkg::IDX_W'(size - 1'b1);
    end
  end

  always_comb begin
    state_next = state;
    lr_next    = lr;
    lc_next    = lc;
    j_next     = j;
    i_next     = i;
    k_next     = k;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_stall = 1'b0;
        cmd.row  = lr;
        cmd.col  = lc;
        if (in_valid) begin
          cmd.load_wr = 1'b1;
          if (lc == nm1) begin
            lc_next = '0;
            if (lr == nm1) begin
              lr_next    = '0;
              state_next = ST_INIT;
            end else begin
              lr_next = lr + 1'b1;
            end
          end else begin
            lc_next = lc + 1'b1;
          end
        end
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        j_next     = '0;
        state_next = ST_COL;
      end
      ST_COL: begin
        cmd.srch_clr = 1'b1;
        cmd.pj       = j;
        i_next       = j;
        state_next   = ST_SRD;
      end
      ST_SRD: begin
        cmd.rd_en = 1'b1;
        cmd.dst   = lud_pkg::DST_SRCH;
        cmd.row   = i;
        cmd.col   = j;
        if (i == nm1) begin
          state_next = ST_SEND;
        end else begin
          i_next = i + 1'b1;
        end
      end
      ST_SEND: state_next = ST_SDEC;
      ST_SDEC: begin
        cmd.pj = j;
        if (status.best_zero) begin
          // Zero column: flag it and move on without elimination.
          cmd.skip_set = 1'b1;
          if (j == nm1) begin
            i_next     = '0;
            k_next     = '0;
            state_next = ST_OREAD;
          end else begin
            j_next     = j + 1'b1;
            state_next = ST_COL;
          end
        end else begin
          state_next = ST_SWAPA;
        end
      end
      ST_SWAPA: begin
        cmd.swap_a = 1'b1;
        cmd.row    = j;
        state_next = ST_SWAPB;
      end
      ST_SWAPB: begin
        cmd.swap_b = 1'b1;
        cmd.pj     = j;
        state_next = ST_PRD;
      end
      ST_PRD: begin
        cmd.rd_en = 1'b1;
        cmd.dst   = lud_pkg::DST_PIV;
        cmd.row   = j;
        cmd.col   = j;
        if (j == nm1) begin
          i_next     = '0;
          k_next     = '0;
          state_next = ST_OREAD;
        end else begin
          i_next     = j + 1'b1;
          state_next = ST_DRD;
        end
      end
      ST_DRD: begin
        cmd.rd_en  = 1'b1;
        cmd.dst    = lud_pkg::DST_NUM;
        cmd.row    = i;
        cmd.col    = j;
        state_next = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (status.div_done) begin
          state_next = ST_LWR;
        end
      end
      ST_LWR: begin
        cmd.l_wr   = 1'b1;
        cmd.row    = i;
        cmd.col    = j;
        k_next     = j + 1'b1;
        state_next = ST_ERJ;
      end
      ST_ERJ: begin
        cmd.rd_en  = 1'b1;
        cmd.dst    = lud_pkg::DST_UJK;
        cmd.row    = j;
        cmd.col    = k;
        state_next = ST_ERI;
      end
      ST_ERI: begin
        cmd.rd_en  = 1'b1;
        cmd.dst    = lud_pkg::DST_UIK;
        cmd.row    = i;
        cmd.col    = k;
        state_next = ST_EMUL;
      end
      ST_EMUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_EADJ;
      end
      ST_EADJ: begin
        cmd.adj    = 1'b1;
        state_next = ST_EWR;
      end
      ST_EWR: begin
        cmd.u_wr = 1'b1;
        cmd.row  = i;
        cmd.col  = k;
        if (k != nm1) begin
          k_next     = k + 1'b1;
          state_next = ST_ERJ;
        end else if (i != nm1) begin
          i_next     = i + 1'b1;
          state_next = ST_DRD;
        end else if (j == nm1) begin
          i_next     = '0;
          k_next     = '0;
          state_next = ST_OREAD;
        end else begin
          j_next     = j + 1'b1;
          state_next = ST_COL;
        end
      end
      ST_OREAD: begin
        cmd.rd_en   = 1'b1;
        cmd.dst     = lud_pkg::DST_OUT;
        cmd.row     = i;
        cmd.col     = k;
        cmd.rd_last = (i == nm1) && (k == nm1);
        state_next  = ST_OLAT;
      end
      // The read data lands in the output word registers during this cycle.
      ST_OLAT: state_next = ST_OSHOW;
      ST_OSHOW: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (k == nm1) begin
            k_next = '0;
            if (i == nm1) begin
              state_next = ST_LOAD;
            end else begin
              i_next     = i + 1'b1;
              state_next = ST_OREAD;
            end
          end else begin
            k_next     = k + 1'b1;
            state_next = ST_OREAD;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      size  <= lud_pkg::SIZE_RESET;
      lr    <= '0;
      lc    <= '0;
      j     <= '0;
      i     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      j     <= j_next;
      i     <= i_next;
      k     <= k_next;
      if (cfg_write) begin
        size <= cfg_data;
        lr   <= '0;
        lc   <= '0;
      end else begin
        lr <= lr_next;
        lc <= lc_next;
      end
    end
  end

endmodule

>>> hw/rtl/lu_decomposition_partial_pivot_core.sv
// LU decomposition with partial pivoting, Q16.16. Loading takes n*n words,
// one word per cycle while in_stall is low. Factoring divides each eliminated
// row's entry by the pivot in the serial divider (one quotient bit per cycle),
// then reads, multiplies, scales and writes back each updated entry through
// the upper store. Each result word is read, latched and shown. Synchronous
// reset returns to loading with size 8; store contents are not cleared.
module lu_decomposition_partial_pivot_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [lud_pkg::SIZE_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [lud_pkg::DATA_W-1:0]  entry_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [lud_pkg::POS_W-1:0]          row_index,
  output logic [lud_pkg::POS_W-1:0]          col_index,
  output logic signed [lud_pkg::DATA_W-1:0]  lower_value,
  output logic signed [lud_pkg::DATA_W-1:0]  upper_value,
  output logic [lud_pkg::POS_W-1:0]          source_row,
  output logic                               singular,
  output logic                               last
);

  lud_pkg::cmd_t             cmd;
  lud_pkg::status_t          status;
  logic [lud_pkg::IDX_W-1:0] out_row, out_col, out_src;

  lud_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lud_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .entry_value (entry_value),
    .status      (status),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_lower   (lower_value),
    .out_upper   (upper_value),
    .out_src     (out_src),
    .out_sing    (singular),
    .out_last    (last)
  );

  assign row_index  = lud_pkg::POS_W'(out_row);
  assign col_index  = lud_pkg::POS_W'(out_col);
  assign source_row = lud_pkg::POS_W'(out_src);

endmodule

>>> hw/rtl/lud_checker.sv
// Port-level checks for the LU decomposition core, bound to the top level.
// Depends on lud_pkg for port widths.
module lud_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               cfg_write,
  input logic [lud_pkg::SIZE_W-1:0]         cfg_data,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic signed [lud_pkg::DATA_W-1:0]  entry_value,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [lud_pkg::POS_W-1:0]          row_index,
  input logic [lud_pkg::POS_W-1:0]          col_index,
  input logic signed [lud_pkg::DATA_W-1:0]  lower_value,
  input logic signed [lud_pkg::DATA_W-1:0]  upper_value,
  input logic [lud_pkg::POS_W-1:0]          source_row,
  input logic                               singular,
  input logic                               last
);

  // No result word follows a reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(row_index) && $stable(col_index)
      && $stable(lower_value) && $stable(upper_value) && $stable(source_row)
      && $stable(last))
    else $error("stalled result word changed");

  // Input words are only taken while no result is pending.
  a_no_load_during_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while results stream");

  // After the final word of a run the core goes back to loading.
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last |=> !out_valid && !in_stall)
    else $error("core did not return to loading after the final word");

endmodule

bind lu_decomposition_partial_pivot_core lud_checker u_chk (.*);
